/* hdl/dap_pkg.sv */
// Package for the decimal amount parser: character codes, item kinds,
// parser phases, error codes and the structs passed between the parts.
// No dependencies; the front end, back end, top level and testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package dap_pkg;

  // Default queue depths
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 4;

  // Field widths
  localparam int CHAR_W   = 8;
  localparam int AMOUNT_W = 64;
  localparam int ERR_W    = 4;
  localparam int ACC_W    = 63;  // integer part never exceeds 2^63-1
  localparam int FVAL_W   = 7;   // fraction value up to 99
  localparam int SUM_W    = 70;  // integer part times 100 plus fraction

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

  // Class of one input transaction, as decided by the front end
  typedef enum logic [2:0] {
    K_DIGIT,
    K_POINT,
    K_PLUS,
    K_MINUS,
    K_OTHER,
    K_END
  } kind_e;

  // Parser phase
  typedef enum logic [1:0] {
    PH_START,
    PH_INT,
    PH_FRAC
  } phase_e;

  // Result error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE           = 4'd0,
    ERR_EMPTY          = 4'd1,
    ERR_SIGN_ONLY      = 4'd2,
    ERR_BAD_INT        = 4'd3,
    ERR_NO_INT         = 4'd4,
    ERR_BAD_FRAC       = 4'd5,
    ERR_TOO_MANY_FRAC  = 4'd6,
    ERR_TRAILING_POINT = 4'd7,
    ERR_OVERFLOW       = 4'd8
  } err_e;

  // Classified item held in the queue between front and back
  typedef struct packed {
    kind_e      kind;
    logic [3:0] digit;
  } item_t;

  // Finished result
  typedef struct packed {
    logic [AMOUNT_W-1:0] amount;
    err_e                err;
  } result_t;

endpackage

`default_nettype wire

/* hdl/dap_queue.sv */
// Small register queue used between front and back and for results.
// Depends on nothing but its parameters; the caller never writes when full
// nor reads when empty.
`timescale 1ns / 1ps
`default_nettype none

module dap_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         wr_en_i,
  input  wire logic [Width-1:0]             wr_data_i,
  input  wire logic                         rd_en_i,
  output logic      [Width-1:0]             rd_data_o,
  output logic      [$clog2(Depth+1)-1:0]   count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // Store the written entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_en_i, rd_en_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign count_o   = count_q;

endmodule

`default_nettype wire

/* hdl/dap_front.sv */
// Front end of the amount parser: accepts input transactions and classifies
// each character into a kind and a digit value.
// Depends on dap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dap_front
  import dap_pkg::*;
(
  input  wire logic              push_i,
  input  wire logic              full_i,
  input  wire logic [CHAR_W-1:0] char_code_i,
  input  wire logic              is_end_i,
  output logic                   wr_en_o,
  output item_t                  item_o
);

  logic [CHAR_W-1:0] offset;

  assign offset  = char_code_i - CHAR_ZERO;
  assign wr_en_o = push_i && !full_i;

  // Classify the character
  always_comb begin
    item_o.digit = offset[3:0];
    if (is_end_i) begin
      item_o.kind = K_END;
    end else if (char_code_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
      item_o.kind = K_DIGIT;
    end else if (char_code_i == CHAR_POINT) begin
      item_o.kind = K_POINT;
    end else if (char_code_i == CHAR_PLUS) begin
      item_o.kind = K_PLUS;
    end else if (char_code_i == CHAR_MINUS) begin
      item_o.kind = K_MINUS;
    end else begin
      item_o.kind = K_OTHER;
    end
  end

endmodule

`default_nettype wire

/* hdl/dap_back.sv */
// Back end of the amount parser: phase machine, integer and fraction
// accumulation, and a two-stage finishing pipeline for end transactions.
// Depends on dap_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dap_back
  import dap_pkg::*;
#(
  parameter int OutDepth = OUT_DEPTH
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          item_valid_i,
  input  wire item_t                         item_i,
  output logic                               item_pop_o,
  input  wire logic [$clog2(OutDepth+1)-1:0] out_count_i,
  output logic                               res_valid_o,
  output result_t                            res_o
);

  localparam int OcW  = $clog2(OutDepth + 1);
  localparam int IntW = ACC_W + 4;  // ten times the accumulator plus a digit

  // Parser state
  phase_e            phase_q, phase_d;
  logic              neg_q, neg_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic              seen_q, seen_d;
  logic [1:0]        fcnt_q, fcnt_d;
  logic [FVAL_W-1:0] fval_q, fval_d;
  err_e              err_q, err_d;

  // Finishing pipeline
  logic              s1_valid_q;
  logic [ACC_W-1:0]  s1_acc_q, s1_acc_d;
  logic [FVAL_W-1:0] s1_frac_q, s1_frac_d;
  logic              s1_neg_q;
  err_e              s1_err_q, s1_err_d;
  logic              s2_valid_q;
  logic [SUM_W-1:0]  s2_sum_q;
  logic              s2_neg_q;
  err_e              s2_err_q;

  logic              is_end, take, room;
  logic [OcW:0]      in_flight;
  logic [IntW-1:0]   int_next;
  logic              int_ovf;
  logic [10:0]       frac_next;
  logic [SUM_W-1:0]  sum;
  logic              sum_ovf;
  err_e              fin_err;
  logic [AMOUNT_W-1:0] magnitude;

  // Take an end transaction only when the result queue has room for it
  assign in_flight = {1'b0, out_count_i} + (OcW + 1)'(s1_valid_q)
                     + (OcW + 1)'(s2_valid_q);
  assign room       = in_flight < (OcW + 1)'(OutDepth);
  assign is_end     = item_i.kind == K_END;
  assign take       = item_valid_i && (!is_end || room);
  assign item_pop_o = take;

  // Multiply-add for the next integer digit and the next fraction digit
  assign int_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                     + IntW'(item_i.digit);
  assign int_ovf   = |int_next[IntW-1:ACC_W];
  assign frac_next = {1'b0, fval_q, 3'b000} + {3'b000, fval_q, 1'b0}
                     + 11'(item_i.digit);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      if (is_end) begin
        phase_d = PH_START;
      end else if (err_q == ERR_NONE) begin
        case (phase_q)
          PH_START: phase_d = PH_INT;
          PH_INT:   if (item_i.kind == K_POINT && seen_q) phase_d = PH_FRAC;
          default:  phase_d = phase_q;
        endcase
      end
    end
  end

  // Accumulate characters and hand end transactions to the pipeline
  always_comb begin
    neg_d     = neg_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    fcnt_d    = fcnt_q;
    fval_d    = fval_q;
    err_d     = err_q;
    s1_acc_d  = acc_q;
    s1_frac_d = fval_q;
    s1_err_d  = err_q;
    if (take && is_end) begin
      // Check for an incomplete amount and scale a single fraction digit
      if (err_q == ERR_NONE) begin
        case (phase_q)
          PH_START: s1_err_d = ERR_EMPTY;
          PH_INT:   if (!seen_q) s1_err_d = ERR_SIGN_ONLY;
          default: begin
            if (fcnt_q == 2'd0) begin
              s1_err_d = ERR_TRAILING_POINT;
            end else if (fcnt_q == 2'd1) begin
              s1_frac_d = frac_next[FVAL_W-1:0] - FVAL_W'(item_i.digit);
            end
          end
        endcase
      end
      neg_d  = 1'b0;
      acc_d  = '0;
      seen_d = 1'b0;
      fcnt_d = '0;
      fval_d = '0;
      err_d  = ERR_NONE;
    end else if (take && err_q == ERR_NONE) begin
      if (phase_q == PH_START && (item_i.kind == K_PLUS || item_i.kind == K_MINUS)) begin
        neg_d = item_i.kind == K_MINUS;
      end else if (phase_q != PH_FRAC) begin
        case (item_i.kind)
          K_POINT: if (!seen_q) err_d = ERR_NO_INT;
          K_DIGIT: begin
            if (int_ovf) begin
              err_d = ERR_OVERFLOW;
            end else begin
              acc_d  = int_next[ACC_W-1:0];
              seen_d = 1'b1;
            end
          end
          default: err_d = ERR_BAD_INT;
        endcase
      end else begin
        case (item_i.kind)
          K_DIGIT: begin
            if (fcnt_q >= 2'd2) begin
              err_d = ERR_TOO_MANY_FRAC;
            end else begin
              fval_d = frac_next[FVAL_W-1:0];
              fcnt_d = fcnt_q + 1'b1;
            end
          end
          default: err_d = ERR_BAD_FRAC;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_START;
      neg_q      <= 1'b0;
      acc_q      <= '0;
      seen_q     <= 1'b0;
      fcnt_q     <= '0;
      fval_q     <= '0;
      err_q      <= ERR_NONE;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      neg_q      <= neg_d;
      acc_q      <= acc_d;
      seen_q     <= seen_d;
      fcnt_q     <= fcnt_d;
      fval_q     <= fval_d;
      err_q      <= err_d;
      s1_valid_q <= take && is_end;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Hold the finishing payload
  always_ff @(posedge clk_i) begin
    if (take && is_end) begin
      s1_acc_q  <= s1_acc_d;
      s1_frac_q <= s1_frac_d;
      s1_neg_q  <= neg_q;
      s1_err_q  <= s1_err_d;
    end
    if (s1_valid_q) begin
      s2_sum_q <= sum;
      s2_neg_q <= s1_neg_q;
      s2_err_q <= s1_err_q;
    end
  end

  // Stage one: integer part times one hundred plus fraction
  assign sum = {1'b0, s1_acc_q, 6'b0} + {2'b0, s1_acc_q, 5'b0}
               + {5'b0, s1_acc_q, 2'b0} + SUM_W'(s1_frac_q);

  // Stage two: overflow check and sign
  assign sum_ovf   = |s2_sum_q[SUM_W-1:AMOUNT_W-1];
  assign fin_err   = (s2_err_q == ERR_NONE && sum_ovf) ? ERR_OVERFLOW : s2_err_q;
  assign magnitude = s2_sum_q[AMOUNT_W-1:0];

  always_comb begin
    res_o.err = fin_err;
    if (fin_err != ERR_NONE) begin
      res_o.amount = '0;
    end else if (s2_neg_q) begin
      res_o.amount = '0 - magnitude;
    end else begin
      res_o.amount = magnitude;
    end
  end

  assign res_valid_o = s2_valid_q;

endmodule

`default_nettype wire

/* hdl/decimal_amount_parser.sv */
// Decimal amount parser. Text arrives one character per transaction on the
// push side, followed by an end transaction that carries no character; the
// end transaction yields one result: a signed amount in hundredths and an
// error code (zero amount on error). A transaction is accepted every cycle
// while full is low. The back end takes character transactions without
// stalling. An end transaction taken from the input queue passes through a
// two-stage finishing pipeline (times one hundred, then overflow check and
// sign) and is then written into the result queue read by the pop side. The
// back end takes an end transaction only when the result queue has room for
// it and every result already in flight; with results popped as they appear
// the block sustains one transaction per cycle.
// Depends on dap_pkg, dap_front, dap_queue and dap_back.
`timescale 1ns / 1ps
`default_nettype none

module decimal_amount_parser
  import dap_pkg::*;
#(
  parameter int MidDepth = MID_DEPTH,
  parameter int OutDepth = OUT_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push,
  output logic                            full,
  input  wire logic [CHAR_W-1:0]          char_code_i,
  input  wire logic                       is_end_i,
  output logic                            empty,
  input  wire logic                       pop,
  output logic signed [AMOUNT_W-1:0]      amount_minor_o,
  output logic        [ERR_W-1:0]         error_code_o
);

  localparam int MidCw = $clog2(MidDepth + 1);
  localparam int OutCw = $clog2(OutDepth + 1);

  logic             mid_wr, mid_rd;
  item_t            front_item, mid_item;
  logic [MidCw-1:0] mid_count;
  logic [OutCw-1:0] out_count;
  logic             res_valid;
  result_t          res, out_res;

  assign full  = mid_count == MidCw'(MidDepth);
  assign empty = out_count == '0;

  // Classify incoming transactions
  dap_front u_front (
    .push_i      (push),
    .full_i      (full),
    .char_code_i (char_code_i),
    .is_end_i    (is_end_i),
    .wr_en_o     (mid_wr),
    .item_o      (front_item)
  );

  // Decouple front and back
  dap_queue #(
    .Width ($bits(item_t)),
    .Depth (MidDepth)
  ) u_mid_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (mid_wr),
    .wr_data_i (front_item),
    .rd_en_i   (mid_rd),
    .rd_data_o (mid_item),
    .count_o   (mid_count)
  );

  // Parse and finish amounts
  dap_back #(
    .OutDepth (OutDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (mid_count != '0),
    .item_i       (mid_item),
    .item_pop_o   (mid_rd),
    .out_count_i  (out_count),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Hold results until popped
  dap_queue #(
    .Width ($bits(result_t)),
    .Depth (OutDepth)
  ) u_out_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_valid),
    .wr_data_i (res),
    .rd_en_i   (pop && !empty),
    .rd_data_o (out_res),
    .count_o   (out_count)
  );

  assign amount_minor_o = out_res.amount;
  assign error_code_o   = out_res.err;

endmodule

`default_nettype wire

/* test/decimal_amount_parser_test.sv */
// Self-checking testbench for decimal_amount_parser: directed, overflow and
// random amount texts under several idle and stall patterns.
// Depends on dap_pkg and the decimal_amount_parser RTL.
`timescale 1ns / 1ps

module decimal_amount_parser_test;
  import dap_pkg::*;

  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int END_WAIT = 12;

  typedef struct packed {
    logic signed [AMOUNT_W-1:0] amount;
    err_e                       err;
  } amount_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic is_end_i = 1'b0;
  logic pop = 1'b0;
  logic full;
  logic empty;
  logic signed [AMOUNT_W-1:0] amount_minor_o;
  logic [ERR_W-1:0] error_code_o;

  // Parse state mirrored by the predictor
  phase_e               text_phase = PH_START;
  logic                 text_negative = 1'b0;
  logic [AMOUNT_W-1:0]  integer_part = '0;
  logic                 integer_seen = 1'b0;
  logic [1:0]           fraction_digits = '0;
  logic [FVAL_W-1:0]    fraction_part = '0;
  err_e                 first_error = ERR_NONE;

  amount_result_t expected_amounts[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  decimal_amount_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .char_code_i   (char_code_i),
    .is_end_i      (is_end_i),
    .empty         (empty),
    .pop           (pop),
    .amount_minor_o(amount_minor_o),
    .error_code_o  (error_code_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // Apply one integer-part character to the mirrored state
  task automatic take_integer_char(input logic [CHAR_W-1:0] c);
    logic [AMOUNT_W-1:0] d;
    d = AMOUNT_W'(c - CHAR_ZERO);
    if (c == CHAR_POINT) begin
      if (!integer_seen) first_error = ERR_NO_INT;
      else text_phase = PH_FRAC;
    end else if (c < CHAR_ZERO || c > CHAR_NINE) begin
      first_error = ERR_BAD_INT;
    end else if (integer_part > (AMOUNT_MAX - d) / 10) begin
      first_error = ERR_OVERFLOW;
    end else begin
      integer_part = integer_part * 10 + d;
      integer_seen = 1'b1;
    end
  endtask

  // Advance the mirrored parser by one accepted transaction; queue the
  // amount that an end transaction produces
  task automatic predict_amount(input logic [CHAR_W-1:0] c, input logic e);
    logic [AMOUNT_W-1:0] frac;
    logic [AMOUNT_W-1:0] total;
    amount_result_t res;
    if (!e) begin
      if (first_error != ERR_NONE) return;
      case (text_phase)
        PH_START: begin
          text_phase = PH_INT;
          if (c == CHAR_PLUS || c == CHAR_MINUS) text_negative = (c == CHAR_MINUS);
          else take_integer_char(c);
        end
        PH_INT: begin
          take_integer_char(c);
        end
        default: begin
          if (c < CHAR_ZERO || c > CHAR_NINE) first_error = ERR_BAD_FRAC;
          else if (fraction_digits >= 2) first_error = ERR_TOO_MANY_FRAC;
          else begin
            fraction_part = FVAL_W'(fraction_part * 10 + (c - CHAR_ZERO));
            fraction_digits = fraction_digits + 2'd1;
          end
        end
      endcase
      return;
    end
    res.err = first_error;
    frac = AMOUNT_W'(fraction_part);
    total = '0;
    if (res.err == ERR_NONE) begin
      case (text_phase)
        PH_START: res.err = ERR_EMPTY;
        PH_INT: if (!integer_seen) res.err = ERR_SIGN_ONLY;
        default: begin
          if (fraction_digits == 0) res.err = ERR_TRAILING_POINT;
          else if (fraction_digits == 1) frac = frac * 10;
        end
      endcase
    end
    if (res.err == ERR_NONE) begin
      if (integer_part > (AMOUNT_MAX - frac) / 100) res.err = ERR_OVERFLOW;
      else total = integer_part * 100 + frac;
    end
    if (res.err != ERR_NONE) total = '0;
    else if (text_negative) total = -total;
    res.amount = total;
    expected_amounts.insert(expected_amounts.size(), res);
    // End of amount: back to the reset state
    text_phase = PH_START;
    text_negative = 1'b0;
    integer_part = '0;
    integer_seen = 1'b0;
    fraction_digits = '0;
    fraction_part = '0;
    first_error = ERR_NONE;
  endtask

  // Offer one transaction and hold it until accepted; called at a falling edge
  task automatic send_item(input logic [CHAR_W-1:0] c, input logic e);
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push <= 1'b1;
    char_code_i <= c;
    is_end_i <= e;
    do @(posedge clk_i); while (full);
    predict_amount(c, e);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Send a whole amount text followed by its end transaction
  task automatic send_amount(input string txt);
    for (int i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    send_item(CHAR_W'($urandom_range(255)), 1'b1);
  endtask

  // Hold the sender until every queued amount has been popped
  task automatic wait_results_drained();
    push <= 1'b0;
    do @(negedge clk_i); while (expected_amounts.size() != 0);
  endtask

  // Empty text, lone sign, sign position, point placement, fraction checks,
  // extreme character codes and the ignored character of an end transaction
  task automatic test_directed();
    send_amount("");
    send_amount("-");
    send_amount("+.");
    send_amount("-1.5");
    send_item("5", 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_amount("1.23.");
    send_amount("7.");
    wait_results_drained();
  endtask

  // Integer and total overflow around the 2^63-1 boundary
  task automatic test_overflow();
    send_amount("9223372036854775807");
    send_amount("92233720368547758.07");
    send_amount("-92233720368547758.07");
    send_amount("92233720368547758.08");
    send_amount("92233720368547758.1");
    send_amount("92233720368547758079");
    send_amount("+00000000000000000000000000123.4");
    wait_results_drained();
  endtask

  // Random amounts: mostly well-formed with random content, some corrupted,
  // some plain noise
  task automatic test_random(input int idle, input int stall, input int count);
    logic [CHAR_W-1:0] txt[$];
    string top_digits;
    int stop_at;
    int n;
    int pick;
    top_digits = "92233720368547758";
    idle_pct = idle;
    stall_pct = stall;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      txt.delete();
      pick = $urandom_range(99);
      if (pick < 8) begin
        n = $urandom_range(6);
        repeat (n) txt.insert(txt.size(), CHAR_W'($urandom_range(255)));
      end else begin
        case ($urandom_range(2))
          0: ;
          1: txt.insert(txt.size(), CHAR_PLUS);
          default: txt.insert(txt.size(), CHAR_MINUS);
        endcase
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Hover around the largest integer part that still fits
          foreach (top_digits[i]) txt.insert(txt.size(), top_digits[i]);
          n = $urandom_range(3);
        end else if (pick < 14) begin
          n = $urandom_range(20, 17);
        end else begin
          n = $urandom_range(6, 1);
        end
        repeat (n) txt.insert(txt.size(), CHAR_ZERO + CHAR_W'($urandom_range(9)));
        if ($urandom_range(99) < 65) begin
          txt.insert(txt.size(), CHAR_POINT);
          pick = $urandom_range(99);
          n = (pick < 10) ? 0 : (pick < 45) ? 1 : (pick < 90) ? 2 : 3;
          repeat (n) txt.insert(txt.size(), CHAR_ZERO + CHAR_W'($urandom_range(9)));
        end
        if ($urandom_range(99) < 15) begin
          case ($urandom_range(3))
            0: txt.insert($urandom_range(txt.size()), CHAR_POINT);
            1: txt.insert($urandom_range(txt.size()), CHAR_PLUS);
            2: txt.insert($urandom_range(txt.size()), CHAR_MINUS);
            default: txt.insert($urandom_range(txt.size()), CHAR_W'($urandom_range(255)));
          endcase
        end
      end
      foreach (txt[i]) send_item(txt[i], 1'b0);
      send_item(CHAR_W'($urandom_range(255)), 1'b1);
    end
    wait_results_drained();
  endtask

  // Drive the pop side with the current stall pattern
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  // Compare each popped result with the oldest expectation
  always @(posedge clk_i) begin
    amount_result_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (expected_amounts.size() == 0) begin
        $error("unexpected result: amount_minor %0d, error_code %0d",
               amount_minor_o, error_code_o);
        mismatch_count++;
      end else begin
        exp_res = expected_amounts.pop_front();
        if (amount_minor_o !== exp_res.amount) begin
          $error("amount_minor: expected %0d, actual %0d",
                 $signed(exp_res.amount), amount_minor_o);
          mismatch_count++;
        end
        if (error_code_o !== exp_res.err) begin
          $error("error_code: expected %0d, actual %0d", exp_res.err, error_code_o);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when no transaction moves on either side for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("decimal_amount_parser: mismatch");
        $finish;
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 0, 280);
    test_random(45, 0, 260);
    test_random(0, 45, 260);
    test_random(23, 23, 260);
    idle_pct = 0;
    stall_pct = 0;
    wait_results_drained();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatch_count == 0 && expected_amounts.size() == 0) begin
      $display("decimal_amount_parser: match");
    end else begin
      $display("decimal_amount_parser: mismatch");
    end
    $finish;
  end

endmodule
